/* rtl/shift_bits_min_error_search_assert.svh */
// ----------------------------------------------------------------------------
// shift_bits_min_error_search assertion macros
// checks on the clock and reset of the module that includes this header
// ----------------------------------------------------------------------------
`ifndef SHIFT_BITS_MIN_ERROR_SEARCH_ASSERT_SVH
`define SHIFT_BITS_MIN_ERROR_SEARCH_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SBMES_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// condition never holds
`define SBMES_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed: label");

`endif

/* rtl/sbmes_pkg.sv */
// ----------------------------------------------------------------------------
// sbmes_pkg
// widths and constants shared by the shift search block
// ----------------------------------------------------------------------------
`default_nettype none

package sbmes_pkg;

	localparam int SAMPLE_W      = 32;
	localparam int SHIFT_W       = 5;
	localparam int ACC_W         = 64;
	localparam int Q_W           = 16;
	localparam int MAG_W         = 32;
	localparam int DIFF_W        = 48;
	localparam int DEF_MAX_SHIFT = 16;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic signed [Q_W-1:0] CLIP_MIN = 16'sh8000;
	localparam logic signed [Q_W-1:0] CLIP_MAX = 16'sh7fff;

endpackage

`default_nettype wire

/* rtl/shift_bits_min_error_search.sv */
// ----------------------------------------------------------------------------
// shift_bits_min_error_search
// power-of-two scale search: picks the shift with least summed squared error
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  input     in         push / full        sample[31:0] signed, last
//  result    out        pop / empty        best_shift[4:0]
//
// one sample is taken every cycle; each shift lane runs four stages
// (clip, error, square, accumulate) and all lanes work side by side
// a channel total passes a two-entry queue, then a registered minimum tree of
// clog2(MAX_SHIFT) levels
// full rises only while a last item waits for room in the totals queue
// reset clears the accumulators and all queues at once, no clearing pass
//
`default_nettype none

module shift_bits_min_error_search #(
	parameter int MAX_SHIFT = sbmes_pkg::DEF_MAX_SHIFT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [sbmes_pkg::SAMPLE_W-1:0] sample,
	input  logic                                  last,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [sbmes_pkg::SHIFT_W-1:0]         best_shift
);
	import sbmes_pkg::*;

	`include "shift_bits_min_error_search_assert.svh"

	// totals queue between the lanes and the minimum tree
	logic                            tq_push;
	logic                            tq_full;
	logic                            tq_pop;
	logic                            tq_empty;
	logic [MAX_SHIFT-1:0][ACC_W-1:0] tq_wdata;
	logic [MAX_SHIFT-1:0][ACC_W-1:0] tq_rdata;

	// result queue in front of the output side
	logic               rq_push;
	logic               rq_full;
	logic [SHIFT_W-1:0] rq_wdata;

	// front: accept samples and accumulate per shift
	sbmes_front #(
		.MAX_SHIFT (MAX_SHIFT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.sample  (sample),
		.last    (last),
		.tq_push (tq_push),
		.tq_full (tq_full),
		.tq_data (tq_wdata)
	);

	// queue holds finished channel totals so the tree may stall on its own
	sbmes_fifo #(
		.WIDTH (MAX_SHIFT * ACC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_totals_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tq_push),
		.wdata  (tq_wdata),
		.full   (tq_full),
		.pop    (tq_pop),
		.rdata  (tq_rdata),
		.empty  (tq_empty)
	);

	// back: find the least total, lower shift on a tie
	sbmes_back #(
		.MAX_SHIFT (MAX_SHIFT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tq_empty (tq_empty),
		.tq_data  (tq_rdata),
		.tq_pop   (tq_pop),
		.rq_push  (rq_push),
		.rq_full  (rq_full),
		.rq_data  (rq_wdata)
	);

	// result queue decouples the tree from the consumer
	sbmes_fifo #(
		.WIDTH (SHIFT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (rq_wdata),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (best_shift),
		.empty  (empty)
	);

	// a shown result is always a legal shift
	`SBMES_ASSERT_IMP(a_result_range, !empty, (best_shift >= SHIFT_W'(1)) && (best_shift <= SHIFT_W'(MAX_SHIFT)))
	// the input side stalls only behind a full totals queue
	`SBMES_ASSERT_IMP(a_full_cause, full, tq_full)
	// no total pushed into a full queue
	`SBMES_ASSERT_NEVER(a_totals_overrun, tq_push && tq_full)
	// the tree never pushes a result into a full queue
	`SBMES_ASSERT_NEVER(a_result_overrun, rq_push && rq_full)

endmodule

`default_nettype wire

/* rtl/sbmes_fifo.sv */
// ----------------------------------------------------------------------------
// sbmes_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
`default_nettype none

module sbmes_fifo #(
	parameter int WIDTH = sbmes_pkg::SHIFT_W,
	parameter int DEPTH = sbmes_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	import sbmes_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

/* rtl/sbmes_front.sv */
// ----------------------------------------------------------------------------
// sbmes_front
// per-shift error lanes and saturating accumulators, one sample per cycle while full is low
// ----------------------------------------------------------------------------
`default_nettype none

module sbmes_front #(
	parameter int MAX_SHIFT = sbmes_pkg::DEF_MAX_SHIFT
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        push,
	output logic                                        full,
	input  logic signed [sbmes_pkg::SAMPLE_W-1:0]       sample,
	input  logic                                        last,
	output logic                                        tq_push,
	input  logic                                        tq_full,
	output logic [MAX_SHIFT-1:0][sbmes_pkg::ACC_W-1:0]  tq_data
);
	import sbmes_pkg::*;

	logic                               adv;
	logic                               v_s1, v_s2, v_s3, v_s4;
	logic                               last_s1, last_s2, last_s3, last_s4;
	logic signed [SAMPLE_W-1:0]         sample_s1, sample_s2;
	logic [MAX_SHIFT-1:0][Q_W-1:0]      q_s2, q_d;
	logic [MAX_SHIFT-1:0][MAG_W-1:0]    mag_s3, mag_d;
	logic [MAX_SHIFT-1:0]               big_s3, big_d;
	logic [MAX_SHIFT-1:0][ACC_W-1:0]    sq_s4, sq_d;
	logic [MAX_SHIFT-1:0][ACC_W-1:0]    acc_q;

	// stall only when a channel total cannot enter the queue
	assign full    = v_s4 && last_s4 && tq_full;
	assign adv     = !full;
	assign tq_push = v_s4 && last_s4 && !tq_full;

	// quotient truncated toward zero, clipped to 16 bits
	always_comb begin
		logic        [SAMPLE_W:0] bias;
		logic signed [SAMPLE_W:0] t;
		logic signed [SAMPLE_W:0] qt;
		for (int l = 0; l < MAX_SHIFT; l++) begin
			bias = sample_s1[SAMPLE_W-1]
				? ((SAMPLE_W+1)'(1) << (l + 1)) - (SAMPLE_W+1)'(1) : '0;
			t  = $signed({sample_s1[SAMPLE_W-1], sample_s1}) + $signed(bias);
			qt = t >>> (l + 1);
			if (qt < (SAMPLE_W+1)'(CLIP_MIN)) begin
				q_d[l] = CLIP_MIN;
			end else if (qt > (SAMPLE_W+1)'(CLIP_MAX)) begin
				q_d[l] = CLIP_MAX;
			end else begin
				q_d[l] = qt[Q_W-1:0];
			end
		end
	end

	// reconstruction error magnitude
	always_comb begin
		logic signed [DIFF_W-1:0] r;
		logic signed [DIFF_W-1:0] d;
		logic        [DIFF_W-1:0] ad;
		for (int l = 0; l < MAX_SHIFT; l++) begin
			r  = DIFF_W'($signed(q_s2[l])) <<< (l + 1);
			d  = r - DIFF_W'(sample_s2);
			ad = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
			mag_d[l] = ad[MAG_W-1:0];
			big_d[l] = |ad[DIFF_W-1:MAG_W];
		end
	end

	// square, saturating when the magnitude needs more than 32 bits
	always_comb begin
		for (int l = 0; l < MAX_SHIFT; l++) begin
			sq_d[l] = big_s3[l] ? '1 : ACC_W'(mag_s3[l]) * ACC_W'(mag_s3[l]);
		end
	end

	// saturating accumulate
	always_comb begin
		logic [ACC_W:0] sum;
		for (int l = 0; l < MAX_SHIFT; l++) begin
			sum = (ACC_W+1)'(acc_q[l]) + (ACC_W+1)'(sq_s4[l]);
			tq_data[l] = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			acc_q <= '0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4) begin
				acc_q <= last_s4 ? '0 : tq_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= sample;
			last_s1   <= last;
			sample_s2 <= sample_s1;
			last_s2   <= last_s1;
			q_s2      <= q_d;
			last_s3   <= last_s2;
			mag_s3    <= mag_d;
			big_s3    <= big_d;
			last_s4   <= last_s3;
			sq_s4     <= sq_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/sbmes_back.sv */
// ----------------------------------------------------------------------------
// sbmes_back
// pipelined minimum tree over the channel totals, lower shift wins ties
// ----------------------------------------------------------------------------
`default_nettype none

module sbmes_back #(
	parameter int MAX_SHIFT = sbmes_pkg::DEF_MAX_SHIFT
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        tq_empty,
	input  logic [MAX_SHIFT-1:0][sbmes_pkg::ACC_W-1:0]  tq_data,
	output logic                                        tq_pop,
	output logic                                        rq_push,
	input  logic                                        rq_full,
	output logic [sbmes_pkg::SHIFT_W-1:0]               rq_data
);
	import sbmes_pkg::*;

	localparam int LEVELS = (MAX_SHIFT > 1) ? $clog2(MAX_SHIFT) : 1;
	localparam int LEAVES = 1 << LEVELS;
	localparam int NODES  = LEAVES - 1;

	logic               adv;
	logic [LEVELS-1:0]  v_q;
	logic [ACC_W-1:0]   leaf_val [LEAVES];
	logic [SHIFT_W-1:0] leaf_idx [LEAVES];
	logic [ACC_W-1:0]   node_val_q [NODES];
	logic [SHIFT_W-1:0] node_idx_q [NODES];
	logic [ACC_W-1:0]   node_val_d [NODES];
	logic [SHIFT_W-1:0] node_idx_d [NODES];

	assign adv     = !(v_q[LEVELS-1] && rq_full);
	assign tq_pop  = !tq_empty && adv;
	assign rq_push = v_q[LEVELS-1] && !rq_full;
	assign rq_data = node_idx_q[0] + SHIFT_W'(1);

	// padding leaves carry the largest value and a higher index, so never win
	always_comb begin
		for (int j = 0; j < LEAVES; j++) begin
			leaf_val[j] = (j < MAX_SHIFT) ? tq_data[j] : '1;
			leaf_idx[j] = SHIFT_W'(j);
		end
	end

	always_comb begin
		logic [ACC_W-1:0]   lv, rv;
		logic [SHIFT_W-1:0] li, ri;
		for (int i = 0; i < NODES; i++) begin
			if (2 * i + 1 >= NODES) begin
				lv = leaf_val[2 * i + 1 - NODES];
				li = leaf_idx[2 * i + 1 - NODES];
				rv = leaf_val[2 * i + 2 - NODES];
				ri = leaf_idx[2 * i + 2 - NODES];
			end else begin
				lv = node_val_q[2 * i + 1];
				li = node_idx_q[2 * i + 1];
				rv = node_val_q[2 * i + 2];
				ri = node_idx_q[2 * i + 2];
			end
			if (rv < lv) begin
				node_val_d[i] = rv;
				node_idx_d[i] = ri;
			end else begin
				node_val_d[i] = lv;
				node_idx_d[i] = li;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[LEVELS-1:0] << 1} | LEVELS'(tq_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			node_val_q <= node_val_d;
			node_idx_q <= node_idx_d;
		end
	end

endmodule

`default_nettype wire
